// File: hdl/tqsu_pkg.sv
package tqsu_pkg;

    localparam int TASKS      = 16;
    localparam int SEMAPHORES = 8;

    localparam int ID_W    = 5;
    localparam int SEM_W   = 3;
    localparam int MODE_W  = 2;
    localparam int CNT_W   = 8;
    localparam int LINK_IW = $clog2(TASKS + 1);
    localparam int SEM_IW  = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;

    localparam logic [MODE_W-1:0] MODE_CREATE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCHEDULE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_P        = 2'd2;
    localparam logic [MODE_W-1:0] MODE_V        = 2'd3;

    localparam logic signed [CNT_W-1:0] CNT_MIN   = 8'sh80;
    localparam logic signed [CNT_W-1:0] CNT_MAX   = 8'sh7F;
    localparam logic signed [CNT_W-1:0] CNT_RESET = 8'sh01;

    typedef struct packed {
        logic latch;     // take the input item and clear the result
        logic create;    // claim the free slot found by the encoder
        logic count;     // update the semaphore count
        logic app_clr;   // clear the link of the task being appended
        logic app_link;  // hook the task onto the tail of the target queue
        logic pop;       // pop the head of the target queue
        logic use_wait;  // target queue is the semaphore's wait queue
        logic load_out;  // copy the result into the output registers
    } tqsu_cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              sem_ok;
        logic              cur_ok;
        logic              free_hit;
        logic              cnt_neg;
        logic              cnt_nonpos;
        logic              pop_hit;
    } tqsu_stat_t;

    function automatic logic valid_id(input logic [ID_W-1:0] id);
        return (id != '0) && (32'(id) <= TASKS);
    endfunction

endpackage

// File: hdl/task_ready_queue_semaphore_unit.sv
// Kernel helper holding one FIFO ready queue and a FIFO wait queue per counting
// semaphore, linked through a per-task next-link table. Each call (create,
// schedule, P, V) gives exactly one result. Calls are handled one at a time: a
// call is taken in and decided, may append a task to a queue or pop a queue head,
// or both, and then waits to load its result while the output result register
// is still full and stalled; a new call is taken only after that. The sequencer
// performs one link-table update per cycle. Counts saturate at -128 and 127; an
// empty queue or no free slot answers found low with task id zero, and task
// slots are never released.
module task_ready_queue_semaphore_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [tqsu_pkg::MODE_W-1:0]  mode,
    input  logic [tqsu_pkg::SEM_W-1:0]   sem_id,
    input  logic [tqsu_pkg::ID_W-1:0]    cur_task,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tqsu_pkg::ID_W-1:0]    task_id,
    output logic                         found,
    output logic                         blocked
);
    import tqsu_pkg::*;

    tqsu_cmd_t  cmd;
    tqsu_stat_t stat;

    tqsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tqsu_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .mode     (mode),
        .sem_id   (sem_id),
        .cur_task (cur_task),
        .task_id  (task_id),
        .found    (found),
        .blocked  (blocked)
    );

endmodule

// File: hdl/tqsu_ctrl.sv
module tqsu_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  tqsu_pkg::tqsu_stat_t stat,
    output tqsu_pkg::tqsu_cmd_t  cmd
);
    import tqsu_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DECIDE   = 3'd1;
    localparam logic [2:0] ST_APP_CLR  = 3'd2;
    localparam logic [2:0] ST_APP_LINK = 3'd3;
    localparam logic [2:0] ST_POP      = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                case (stat.mode)
                    MODE_CREATE:
                    begin
                        if (stat.free_hit)
                        begin
                            cmd.create = 1'b1;
                            state_next = ST_APP_CLR;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    MODE_SCHEDULE:
                    begin
                        state_next = ST_POP;
                    end
                    MODE_P:
                    begin
                        if (stat.sem_ok && stat.cur_ok)
                        begin
                            cmd.count  = 1'b1;
                            state_next = stat.cnt_neg ? ST_APP_CLR : ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        if (stat.sem_ok)
                        begin
                            cmd.count  = 1'b1;
                            state_next = stat.cnt_nonpos ? ST_POP : ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                        end
                    end
                endcase
            end
            ST_APP_CLR:
            begin
                cmd.app_clr  = 1'b1;
                cmd.use_wait = (stat.mode == MODE_P);
                state_next   = ST_APP_LINK;
            end
            ST_APP_LINK:
            begin
                cmd.app_link = 1'b1;
                cmd.use_wait = (stat.mode == MODE_P);
                // A blocking P still has to hand over to the next ready task.
                state_next   = (stat.mode == MODE_P) ? ST_POP : ST_DONE;
            end
            ST_POP:
            begin
                cmd.pop      = 1'b1;
                cmd.use_wait = (stat.mode == MODE_V);
                if ((stat.mode == MODE_V) && stat.pop_hit)
                begin
                    state_next = ST_APP_CLR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// File: hdl/tqsu_dpath.sv
module tqsu_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tqsu_pkg::tqsu_cmd_t          cmd,
    output tqsu_pkg::tqsu_stat_t         stat,
    input  logic [tqsu_pkg::MODE_W-1:0]  mode,
    input  logic [tqsu_pkg::SEM_W-1:0]   sem_id,
    input  logic [tqsu_pkg::ID_W-1:0]    cur_task,
    output logic [tqsu_pkg::ID_W-1:0]    task_id,
    output logic                         found,
    output logic                         blocked
);
    import tqsu_pkg::*;

    logic [ID_W-1:0]         link_reg [0:TASKS];
    logic [TASKS:1]          slot_used_reg;
    logic [ID_W-1:0]         ready_head_reg;
    logic [ID_W-1:0]         ready_tail_reg;
    logic signed [CNT_W-1:0] count_reg [0:SEMAPHORES-1];
    logic [ID_W-1:0]         wait_head_reg [0:SEMAPHORES-1];
    logic [ID_W-1:0]         wait_tail_reg [0:SEMAPHORES-1];

    logic [MODE_W-1:0] mode_reg;
    logic [SEM_W-1:0]  sem_reg;
    logic [ID_W-1:0]   cur_reg;
    logic [ID_W-1:0]   app_id_reg;
    logic [ID_W-1:0]   tid_reg;
    logic              found_reg;
    logic              blocked_reg;
    logic [ID_W-1:0]   task_id_reg;
    logic              found_out_reg;
    logic              blocked_out_reg;

    logic [SEM_IW-1:0]       sem_idx;
    logic                    free_hit;
    logic [ID_W-1:0]         free_id;
    logic signed [CNT_W-1:0] cnt_cur;
    logic signed [CNT_W-1:0] cnt_next;
    logic [ID_W-1:0]         tgt_head;
    logic [ID_W-1:0]         tgt_tail;
    logic                    tgt_live;
    logic [ID_W-1:0]         head_link;
    logic                    head_ok;
    logic                    wr_en;
    logic [ID_W-1:0]         wr_addr;
    logic [ID_W-1:0]         wr_data;
    logic                    ht_en;
    logic [ID_W-1:0]         head_new;
    logic [ID_W-1:0]         tail_new;

    assign sem_idx = SEM_IW'(sem_reg);

    // Lowest free slot.
    always_comb
    begin
        free_hit = 1'b0;
        free_id  = '0;
        for (int i = TASKS; i >= 1; i--)
        begin
            if (!slot_used_reg[i])
            begin
                free_hit = 1'b1;
                free_id  = ID_W'(i);
            end
        end
    end

    // Saturating count step: P counts down, V counts up.
    always_comb
    begin
        cnt_cur  = count_reg[sem_idx];
        cnt_next = cnt_cur;
        if (mode_reg == MODE_P)
        begin
            if (cnt_cur != CNT_MIN)
            begin
                cnt_next = cnt_cur - CNT_W'(1);
            end
        end
        else if (cnt_cur != CNT_MAX)
        begin
            cnt_next = cnt_cur + CNT_W'(1);
        end
    end

    assign tgt_head  = cmd.use_wait ? wait_head_reg[sem_idx] : ready_head_reg;
    assign tgt_tail  = cmd.use_wait ? wait_tail_reg[sem_idx] : ready_tail_reg;
    assign tgt_live  = valid_id(tgt_head) && valid_id(tgt_tail);
    assign head_ok   = valid_id(tgt_head);
    assign head_link = link_reg[LINK_IW'(tgt_head)];

    // One write to the link table and one head/tail update per cycle.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = app_id_reg;
        wr_data  = '0;
        ht_en    = 1'b0;
        head_new = tgt_head;
        tail_new = tgt_tail;
        if (cmd.app_clr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.app_link)
        begin
            ht_en    = 1'b1;
            tail_new = app_id_reg;
            if (tgt_live)
            begin
                wr_en   = 1'b1;
                wr_addr = tgt_tail;
                wr_data = app_id_reg;
            end
            else
            begin
                head_new = app_id_reg;
            end
        end
        else if (cmd.pop)
        begin
            ht_en = 1'b1;
            if (head_ok)
            begin
                wr_en   = 1'b1;
                wr_addr = tgt_head;
                if (valid_id(head_link))
                begin
                    head_new = head_link;
                end
                else
                begin
                    head_new = '0;
                    tail_new = '0;
                end
            end
            else
            begin
                head_new = '0;
                tail_new = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= TASKS; i++)
            begin
                link_reg[i] <= '0;
            end
            slot_used_reg  <= '0;
            ready_head_reg <= '0;
            ready_tail_reg <= '0;
            for (int s = 0; s < SEMAPHORES; s++)
            begin
                count_reg[s]     <= CNT_RESET;
                wait_head_reg[s] <= '0;
                wait_tail_reg[s] <= '0;
            end
        end
        else
        begin
            if (wr_en)
            begin
                link_reg[LINK_IW'(wr_addr)] <= wr_data;
            end
            if (cmd.create)
            begin
                slot_used_reg[free_id] <= 1'b1;
            end
            if (cmd.count)
            begin
                count_reg[sem_idx] <= cnt_next;
            end
            if (ht_en)
            begin
                if (cmd.use_wait)
                begin
                    wait_head_reg[sem_idx] <= head_new;
                    wait_tail_reg[sem_idx] <= tail_new;
                end
                else
                begin
                    ready_head_reg <= head_new;
                    ready_tail_reg <= tail_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg    <= mode;
            sem_reg     <= sem_id;
            cur_reg     <= cur_task;
            tid_reg     <= '0;
            found_reg   <= 1'b0;
            blocked_reg <= 1'b0;
        end
        if (cmd.create)
        begin
            app_id_reg <= free_id;
            tid_reg    <= free_id;
            found_reg  <= 1'b1;
        end
        if (cmd.count && (mode_reg == MODE_P))
        begin
            app_id_reg  <= cur_reg;
            blocked_reg <= cnt_next[CNT_W-1];
        end
        if (cmd.pop)
        begin
            app_id_reg <= head_ok ? tgt_head : '0;
            tid_reg    <= head_ok ? tgt_head : '0;
            found_reg  <= head_ok;
        end
        if (cmd.load_out)
        begin
            task_id_reg     <= tid_reg;
            found_out_reg   <= found_reg;
            blocked_out_reg <= blocked_reg;
        end
    end

    always_comb
    begin
        stat.mode       = mode_reg;
        stat.sem_ok     = (32'(sem_reg) < SEMAPHORES);
        stat.cur_ok     = valid_id(cur_reg);
        stat.free_hit   = free_hit;
        stat.cnt_neg    = cnt_next[CNT_W-1];
        stat.cnt_nonpos = cnt_next[CNT_W-1] || (cnt_next == '0);
        stat.pop_hit    = head_ok;
    end

    assign task_id = task_id_reg;
    assign found   = found_out_reg;
    assign blocked = blocked_out_reg;

endmodule

// File: hdl/tqsu_checker.sv
module tqsu_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [tqsu_pkg::ID_W-1:0]    task_id,
    input logic                         found,
    input logic                         blocked
);
    import tqsu_pkg::*;

    // A result that claims a task must name a real one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found) |-> ((task_id != '0) && (32'(task_id) <= TASKS)))
    else $error("found result with an invalid task id");

    // Without a valid task the id reads as none.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (task_id == '0))
    else $error("task id not zero on a not-found result");

    // Calls are handled one at a time, so a transfer in makes the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a call is in progress");

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(task_id) && $stable(found)
                                      && $stable(blocked)))
    else $error("stalled result changed");

endmodule

bind task_ready_queue_semaphore_unit tqsu_checker u_tqsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .task_id   (task_id),
    .found     (found),
    .blocked   (blocked)
);
